>>> rtl/rsenc_pkg.sv
// shared types, constants and the channel encoder function for the led strip encoder
`default_nettype none

package rsenc_pkg;

    localparam int FbDepth  = 16;
    localparam int FbAw     = $clog2(FbDepth);
    localparam int ColorW   = 24;
    localparam int ChunkW   = 64;
    localparam int DimShift = 3;
    localparam int TailLen  = 3;

    localparam logic [7:0] ByteZero = 8'h80;
    localparam logic [7:0] ByteOne  = 8'hF8;
    localparam logic [7:0] ChanMax  = 8'd255;

    localparam logic [7:0] ModeChase = 8'd0;
    localparam logic [7:0] ModeAll   = 8'd1;
    localparam logic [7:0] ModeFast  = 8'd2;

    localparam logic [7:0] StepChase = 8'd5;
    localparam logic [7:0] StepAll   = 8'd3;
    localparam logic [7:0] StepFast  = 8'd15;
    localparam logic [7:0] StepOther = 8'd1;

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_REFRESH = 2'd1,
        CMD_RAINBOW = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_RED_UP   = 2'd0,
        PH_RED_GRN  = 2'd1,
        PH_GRN_BLU  = 2'd2,
        PH_BLU_RED  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAINT,
        ST_READ,
        ST_EMIT,
        ST_TAIL
    } state_t;

    typedef enum logic [1:0] {
        CH_GREEN = 2'd0,
        CH_RED   = 2'd1,
        CH_BLUE  = 2'd2
    } chan_t;

    typedef struct packed {
        logic       load;
        logic [7:0] value;
        logic       zero;
        logic       last;
    } chunk_t;

    function automatic logic [ChunkW-1:0] encode_channel(input logic [7:0] ch);
        logic [7:0]        v;
        logic [ChunkW-1:0] word;
        v    = ch >> DimShift;
        word = '0;
        for (int k = 0; k < 8; k++) begin
            word[ChunkW-1-8*k -: 8] = v[7-k] ? ByteOne : ByteZero;
        end
        return word;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rsenc_fb_ram.sv
// color frame buffer memory with per-entry valid bits and registered read
`default_nettype none

module rsenc_fb_ram (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              wr_en,
    input  wire logic [rsenc_pkg::FbAw-1:0]        wr_addr,
    input  wire logic [rsenc_pkg::ColorW-1:0]      wr_data,
    input  wire logic                              rd_en,
    input  wire logic [rsenc_pkg::FbAw-1:0]        rd_addr,
    output logic      [rsenc_pkg::ColorW-1:0]      rd_data
);

    logic [rsenc_pkg::ColorW-1:0] mem [rsenc_pkg::FbDepth];
    logic [rsenc_pkg::FbDepth-1:0] valid_reg;
    logic [rsenc_pkg::ColorW-1:0]  rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    // unwritten entries read as zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/rsenc_encoder.sv
// spi byte expansion of one channel into the output register
`default_nettype none

module rsenc_encoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rsenc_pkg::chunk_t             chunk,
    output logic                               ready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rsenc_pkg::ChunkW-1:0]       m_tdata,   // spi_bytes
    output logic                               m_tlast
);

    logic                        valid_reg, valid_next;
    logic [rsenc_pkg::ChunkW-1:0] data_reg;
    logic                        last_reg;

    always_comb begin
        ready      = !valid_reg || m_tready;
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (chunk.load && ready) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (chunk.load && ready) begin
            data_reg <= chunk.zero ? '0 : rsenc_pkg::encode_channel(chunk.value);
            last_reg <= chunk.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

>>> rtl/rgb_strip_rainbow_spi_encoder.sv
// top level: command sequencer, color wheel and frame buffer refresh for an led strip
//
// input channel s_*: one command per transaction; s_tuser carries the command
// code, s_tdata the index, color, count and mode fields. output channel m_*:
// one 64-bit chunk of eight spi bytes per transaction, first byte in the top
// bits; m_tlast marks the final chunk of the zero reset frame.
// s_tready is high only while the sequencer is idle; one command is worked on
// at a time. a refresh of c leds reads the frame buffer one entry at a time:
// a buffer read for each led, then its three chunks, and after the last led
// three zero chunks. a rainbow step in chase, fast or all-together mode first
// paints one entry, or each entry up to the led count (at most 16) in the
// all-together mode, then refreshes if the count is valid. the buffer read
// ahead of each led is registered; chunks go out one per cycle unless stalled.
// when the receiver stalls, the output register holds its chunk and the
// sequencer waits; no chunk is lost or repeated.
// after reset the frame buffer reads as all zero, the wheel is pure red in the
// red-to-green phase and the transfer counter is zero.
`default_nettype none

module rgb_strip_rainbow_spi_encoder (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // led_index, red, green, blue, led_count, effect_mode
    input  wire logic [1:0]   s_tuser,   // command
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // spi_bytes
    output logic              m_tlast
);

    localparam int Aw = rsenc_pkg::FbAw;

    rsenc_pkg::state_t state_reg, state_next;
    logic [7:0]    count_reg, count_next;
    logic [7:0]    mode_reg, mode_next;
    logic [Aw-1:0] idx_reg, idx_next;
    logic [1:0]    ch_reg, ch_next;
    logic [7:0]    wr_reg, wr_next;
    logic [7:0]    wg_reg, wg_next;
    logic [7:0]    wb_reg, wb_next;
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    xfer_reg, xfer_next;

    logic       accept;
    logic [1:0] cmd;
    logic [7:0] in_index, in_red, in_green, in_blue, in_count, in_mode;

    logic                   wr_en, rd_en;
    logic [Aw-1:0]          wr_addr;
    logic [rsenc_pkg::ColorW-1:0] wr_data, rd_data;

    rsenc_pkg::chunk_t chunk;
    logic              enc_ready;

    logic [1:0] ph;
    logic [7:0] step;
    logic       count_ok;
    logic       last_led;

    assign cmd      = s_tuser;
    assign in_index = s_tdata[7:0];
    assign in_red   = s_tdata[15:8];
    assign in_green = s_tdata[23:16];
    assign in_blue  = s_tdata[31:24];
    assign in_count = s_tdata[39:32];
    assign in_mode  = s_tdata[47:40];

    assign s_tready = (state_reg == rsenc_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign count_ok = (count_reg != 8'd0) && (count_reg <= 8'(rsenc_pkg::FbDepth));
    assign last_led = ({{(8-Aw){1'b0}}, idx_reg} + 8'd1) == count_reg;

    // color wheel phase from the current color, and step size for the incoming mode
    always_comb begin
        ph = phase_reg;
        if (wr_reg == rsenc_pkg::ChanMax && wg_reg == 8'd0 && wb_reg == 8'd0) begin
            ph = rsenc_pkg::PH_RED_GRN;
        end
        if (wg_reg == rsenc_pkg::ChanMax && wr_reg == 8'd0) begin
            ph = rsenc_pkg::PH_GRN_BLU;
        end
        if (wb_reg == rsenc_pkg::ChanMax && wr_reg == 8'd0) begin
            ph = rsenc_pkg::PH_BLU_RED;
        end
        case (in_mode)
            rsenc_pkg::ModeChase: step = rsenc_pkg::StepChase;
            rsenc_pkg::ModeAll:   step = rsenc_pkg::StepAll;
            rsenc_pkg::ModeFast:  step = rsenc_pkg::StepFast;
            default:              step = rsenc_pkg::StepOther;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        ch_next    = ch_reg;
        wr_next    = wr_reg;
        wg_next    = wg_reg;
        wb_next    = wb_reg;
        phase_next = phase_reg;
        xfer_next  = xfer_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = {wr_reg, wg_reg, wb_reg};
        rd_en      = 1'b0;
        chunk      = '0;

        case (state_reg)
            rsenc_pkg::ST_IDLE: begin
                if (accept) begin
                    count_next = in_count;
                    mode_next  = in_mode;
                    idx_next   = '0;
                    ch_next    = rsenc_pkg::CH_GREEN;
                    case (cmd)
                        rsenc_pkg::CMD_SET: begin
                            if (in_index < 8'(rsenc_pkg::FbDepth)) begin
                                wr_en   = 1'b1;
                                wr_addr = in_index[Aw-1:0];
                                wr_data = {in_red, in_green, in_blue};
                            end
                        end
                        rsenc_pkg::CMD_REFRESH: begin
                            if (in_count != 8'd0 && in_count <= 8'(rsenc_pkg::FbDepth)) begin
                                state_next = rsenc_pkg::ST_READ;
                            end
                        end
                        rsenc_pkg::CMD_RAINBOW: begin
                            phase_next = ph;
                            case (ph)
                                rsenc_pkg::PH_RED_UP: begin
                                    wr_next = wr_reg + step;
                                end
                                rsenc_pkg::PH_RED_GRN: begin
                                    wr_next = wr_reg - step;
                                    wg_next = wg_reg + step;
                                end
                                rsenc_pkg::PH_GRN_BLU: begin
                                    wg_next = wg_reg - step;
                                    wb_next = wb_reg + step;
                                end
                                default: begin
                                    wb_next = wb_reg - step;
                                    wr_next = wr_reg + step;
                                end
                            endcase
                            if (in_mode == rsenc_pkg::ModeChase || in_mode == rsenc_pkg::ModeFast
                                || (in_mode == rsenc_pkg::ModeAll && in_count != 8'd0)) begin
                                state_next = rsenc_pkg::ST_PAINT;
                            end else if (in_count != 8'd0
                                         && in_count <= 8'(rsenc_pkg::FbDepth)) begin
                                state_next = rsenc_pkg::ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            rsenc_pkg::ST_PAINT: begin
                wr_en = 1'b1;
                if (mode_reg == rsenc_pkg::ModeAll) begin
                    wr_addr = idx_reg;
                end else begin
                    wr_addr = xfer_reg[Aw-1:0];
                end
                if (mode_reg == rsenc_pkg::ModeAll && !last_led
                    && idx_reg != Aw'(rsenc_pkg::FbDepth - 1)) begin
                    idx_next = idx_reg + Aw'(1);
                end else begin
                    idx_next   = '0;
                    state_next = count_ok ? rsenc_pkg::ST_READ : rsenc_pkg::ST_IDLE;
                end
            end

            rsenc_pkg::ST_READ: begin
                rd_en      = 1'b1;
                ch_next    = rsenc_pkg::CH_GREEN;
                state_next = rsenc_pkg::ST_EMIT;
            end

            rsenc_pkg::ST_EMIT: begin
                chunk.load = 1'b1;
                case (ch_reg)
                    rsenc_pkg::CH_GREEN: chunk.value = rd_data[15:8];
                    rsenc_pkg::CH_RED:   chunk.value = rd_data[23:16];
                    default:             chunk.value = rd_data[7:0];
                endcase
                if (enc_ready) begin
                    if (ch_reg == rsenc_pkg::CH_BLUE) begin
                        ch_next = rsenc_pkg::CH_GREEN;
                        if (last_led) begin
                            state_next = rsenc_pkg::ST_TAIL;
                        end else begin
                            idx_next   = idx_reg + Aw'(1);
                            state_next = rsenc_pkg::ST_READ;
                        end
                    end else begin
                        ch_next = ch_reg + 2'd1;
                    end
                end
            end

            rsenc_pkg::ST_TAIL: begin
                chunk.load = 1'b1;
                chunk.zero = 1'b1;
                chunk.last = (ch_reg == 2'(rsenc_pkg::TailLen - 1));
                if (enc_ready) begin
                    if (ch_reg == 2'(rsenc_pkg::TailLen - 1)) begin
                        ch_next    = 2'd0;
                        xfer_next  = xfer_reg + count_reg + 8'd1;
                        state_next = rsenc_pkg::ST_IDLE;
                    end else begin
                        ch_next = ch_reg + 2'd1;
                    end
                end
            end

            default: begin
                state_next = rsenc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsenc_pkg::ST_IDLE;
            idx_reg   <= '0;
            ch_reg    <= 2'd0;
            wr_reg    <= rsenc_pkg::ChanMax;
            wg_reg    <= 8'd0;
            wb_reg    <= 8'd0;
            phase_reg <= rsenc_pkg::PH_RED_GRN;
            xfer_reg  <= 8'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            ch_reg    <= ch_next;
            wr_reg    <= wr_next;
            wg_reg    <= wg_next;
            wb_reg    <= wb_next;
            phase_reg <= phase_next;
            xfer_reg  <= xfer_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
        mode_reg  <= mode_next;
    end

    rsenc_fb_ram u_fb_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    rsenc_encoder u_encoder (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .chunk    (chunk),
        .ready    (enc_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
